// File: design/sls_pkg.sv
`default_nettype none
package sls_pkg;

  localparam int DayW   = 9;
  localparam int HourW  = 13;
  localparam int EarlyW = 12;
  localparam int MinW   = 13;
  localparam int TabN   = 11;
  localparam int TabIdxW = 4;
  localparam int TabW   = 13;
  localparam int NumW   = 18;

  // register map (word index)
  localparam logic REG_EARLIEST_ON    = 1'b0;
  localparam logic REG_MIN_DAY_LENGTH = 1'b1;

  localparam logic [EarlyW-1:0] EARLY_RESET = 12'd1536;
  localparam logic [MinW-1:0]   MIN_RESET   = 13'd3584;
  localparam logic [EarlyW-1:0] EARLY_LIMIT = 12'd3072;
  localparam logic [EarlyW-1:0] EARLY_CLAMP = 12'd3069;
  localparam logic [MinW-1:0]   MIN_LIMIT   = 13'd6144;
  localparam logic [MinW-1:0]   MIN_CLAMP   = 13'd6141;
  localparam logic [MinW-1:0]   MIN_FLOOR   = 13'd3;

  localparam logic [DayW-1:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [DayW-1:0] SUMMER_FIRST  = 9'd90;
  localparam logic [DayW-1:0] SUMMER_LAST   = 9'd299;
  localparam logic [5:0]      DAY_STEP      = 6'd40;
  // d/40 == (d*205) >> 13 for d < 365
  localparam logic [7:0]      RECIP_STEP    = 8'd205;
  localparam int              RECIP_SHIFT   = 13;
  // x/40 == (x*209716) >> 23 for x < 2^18
  localparam logic [NumW-1:0] DIV_K         = 18'd209716;
  localparam int              DIV_SHIFT     = 23;
  localparam logic [4:0]      ROUND_HALF    = 5'd20;
  localparam logic [TabW-1:0] ONE_HOUR      = 13'd256;

  typedef logic [TabW-1:0] tab_val_t;

  localparam tab_val_t RISE_TAB [TabN] = '{
    13'd2381, 13'd2240, 13'd1929, 13'd1613, 13'd1438, 13'd1523,
    13'd1737, 13'd1958, 13'd2206, 13'd2377, 13'd2274
  };
  localparam tab_val_t SET_TAB [TabN] = '{
    13'd4574, 13'd4809, 13'd5060, 13'd5295, 13'd5483, 13'd5457,
    13'd5197, 13'd4860, 13'd4587, 13'd4557, 13'd4774
  };

  // window arithmetic in 1/512 h, signed
  typedef logic signed [15:0] tm_t;

  typedef struct packed {
    logic             valid;
    logic [TabW-1:0]  rise;
    logic [TabW-1:0]  sunset;
    logic [HourW-1:0] hour;
  } sls_sun_t;

endpackage
`default_nettype wire

// File: design/sls_interp.sv
`default_nettype none
module sls_interp
  import sls_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [DayW-1:0]  in_day,
  input  wire logic [HourW-1:0] in_hour,
  output sls_sun_t              sun
);

  // stage 1: day mod 365, table segment and weight
  logic [DayW:0]       day_sub;
  logic [DayW-1:0]     dm;
  logic [16:0]         idx_prod;
  logic [TabIdxW-1:0]  idx_nxt;
  logic [DayW-1:0]     seg_base;
  logic [DayW-1:0]     w2_full;
  logic [5:0]          w2_nxt;
  logic                adj_nxt;

  logic                v1_r;
  logic [TabIdxW-1:0]  idx_r;
  logic [5:0]          w2_r;
  logic                adj1_r;
  logic [HourW-1:0]    hour1_r;

  assign day_sub  = {1'b0, in_day} - {1'b0, DAYS_PER_YEAR};
  assign dm       = (in_day >= DAYS_PER_YEAR) ? day_sub[DayW-1:0] : in_day;
  assign idx_prod = {8'b0, dm} * {9'b0, RECIP_STEP};
  assign idx_nxt  = idx_prod[RECIP_SHIFT +: TabIdxW];
  assign seg_base = {5'b0, idx_nxt} * {3'b0, DAY_STEP};
  assign w2_full  = dm - seg_base;
  assign w2_nxt   = w2_full[5:0];
  assign adj_nxt  = (dm < SUMMER_FIRST) || (dm > SUMMER_LAST);

  // stage 2: weighted sum of neighbouring samples, plus rounding half
  logic [5:0]          w1;
  logic [TabIdxW-1:0]  idx_hi;
  logic [18:0]         rise_sum;
  logic [18:0]         set_sum;
  logic [NumW-1:0]     rise_num_nxt;
  logic [NumW-1:0]     set_num_nxt;

  logic                v2_r;
  logic [NumW-1:0]     rise_num_r;
  logic [NumW-1:0]     set_num_r;
  logic                adj2_r;
  logic [HourW-1:0]    hour2_r;

  assign w1       = DAY_STEP - w2_r;
  assign idx_hi   = idx_r + 4'd1;
  assign rise_sum = {13'b0, w1} * {6'b0, RISE_TAB[idx_r]}
                  + {13'b0, w2_r} * {6'b0, RISE_TAB[idx_hi]}
                  + {14'b0, ROUND_HALF};
  assign set_sum  = {13'b0, w1} * {6'b0, SET_TAB[idx_r]}
                  + {13'b0, w2_r} * {6'b0, SET_TAB[idx_hi]}
                  + {14'b0, ROUND_HALF};
  assign rise_num_nxt = rise_sum[NumW-1:0];
  assign set_num_nxt  = set_sum[NumW-1:0];

  // stage 3: divide by 40 through reciprocal, seasonal hour shift
  logic [2*NumW-1:0]   rise_q;
  logic [2*NumW-1:0]   set_q;
  logic [TabW-1:0]     rise_nxt;
  logic [TabW-1:0]     set_nxt;

  assign rise_q   = {{NumW{1'b0}}, rise_num_r} * {{NumW{1'b0}}, DIV_K};
  assign set_q    = {{NumW{1'b0}}, set_num_r} * {{NumW{1'b0}}, DIV_K};
  assign rise_nxt = rise_q[DIV_SHIFT +: TabW] - (adj2_r ? ONE_HOUR : '0);
  assign set_nxt  = set_q[DIV_SHIFT +: TabW] - (adj2_r ? ONE_HOUR : '0);

  sls_sun_t sun_r;
  assign sun = sun_r;

  // valid bits are reset, data fields only follow the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sun_r.valid <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      sun_r.valid <= v2_r;
    end
    if (en) begin
      idx_r        <= idx_nxt;
      w2_r         <= w2_nxt;
      adj1_r       <= adj_nxt;
      hour1_r      <= in_hour;
      rise_num_r   <= rise_num_nxt;
      set_num_r    <= set_num_nxt;
      adj2_r       <= adj1_r;
      hour2_r      <= hour1_r;
      sun_r.rise   <= rise_nxt;
      sun_r.sunset <= set_nxt;
      sun_r.hour   <= hour2_r;
    end
  end

endmodule
`default_nettype wire

// File: design/sls_window.sv
`default_nettype none
module sls_window
  import sls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  sls_sun_t               sun,
  input  wire logic [EarlyW-1:0] early,
  input  wire logic [MinW-1:0]   minlen,
  output logic                   out_valid,
  output logic                   light_on
);

  // stage 4: morning window edges, all in 1/512 h
  tm_t rise_t, set_t, min_t, early2;
  tm_t mon_raw, mon_nxt, rise2, moff_nxt;
  logic deficit_nxt;

  assign rise_t   = tm_t'({3'b0, sun.rise});
  assign set_t    = tm_t'({3'b0, sun.sunset});
  assign min_t    = tm_t'({3'b0, minlen});
  assign early2   = tm_t'({3'b0, early, 1'b0});
  assign rise2    = rise_t <<< 1;
  assign mon_raw  = rise_t + set_t - min_t;
  assign mon_nxt  = (mon_raw < early2) ? early2 : mon_raw;
  assign moff_nxt = (rise2 >= mon_nxt) ? rise2 : mon_nxt;
  assign deficit_nxt = (set_t - rise_t) < min_t;

  logic v4_r, deficit4_r;
  tm_t  mon4_r, moff4_r, eon4_r, nat4_r, min4_r;
  logic [HourW:0] h4_r;

  // stage 5: evening window end
  tm_t lit, eoff_nxt;
  assign lit      = nat4_r + moff4_r - mon4_r;
  assign eoff_nxt = (lit < min4_r) ? eon4_r + min4_r - lit : eon4_r;

  logic v5_r, deficit5_r;
  tm_t  mon5_r, moff5_r, eon5_r, eoff5_r;
  logic [HourW:0] h5_r;

  // stage 6: compare time against both windows
  tm_t h_t;
  logic on_nxt;
  assign h_t    = tm_t'({2'b0, h5_r});
  assign on_nxt = deficit5_r &&
                  (((mon5_r <= h_t) && (h_t < moff5_r)) ||
                   ((eon5_r <= h_t) && (h_t < eoff5_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4_r      <= sun.valid;
      v5_r      <= v4_r;
      out_valid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deficit4_r <= deficit_nxt;
      mon4_r     <= mon_nxt;
      moff4_r    <= moff_nxt;
      eon4_r     <= set_t <<< 1;
      nat4_r     <= (set_t - rise_t) <<< 1;
      min4_r     <= min_t <<< 1;
      h4_r       <= {sun.hour, 1'b0};
      deficit5_r <= deficit4_r;
      mon5_r     <= mon4_r;
      moff5_r    <= moff4_r;
      eon5_r     <= eon4_r;
      eoff5_r    <= eoff_nxt;
      h5_r       <= h4_r;
      light_on   <= on_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/supplemental_light_scheduler.sv
// Supplemental light scheduler: decides per (day, time) transfer whether the lamp is on.
// Throughput: one transfer per cycle while the output is not stalled; six register
// stages (interpolation, /40, windows).
// A stalled output freezes the whole pipeline; in_tready = !out_tvalid || out_tready.
// Reset (rst_n low, synchronous): all stage valid bits cleared, earliest_on = 1536,
// min_day_length = 3584.
`default_nettype none
module supplemental_light_scheduler
  import sls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [8:0] day_of_year, [21:9] hour_of_day, [23:22] zero
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] light_on, [7:1] zero
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // ---------------------------------------------------------------
  // Configuration registers; word index is paddr[2]
  // ---------------------------------------------------------------
  logic [EarlyW-1:0] earliest_on_r;
  logic [MinW-1:0]   min_day_length_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      earliest_on_r    <= EARLY_RESET;
      min_day_length_r <= MIN_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_EARLIEST_ON:    earliest_on_r    <= cfg_pwdata[EarlyW-1:0];
        REG_MIN_DAY_LENGTH: min_day_length_r <= cfg_pwdata[MinW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_EARLIEST_ON:    cfg_prdata = {20'b0, earliest_on_r};
      REG_MIN_DAY_LENGTH: cfg_prdata = {19'b0, min_day_length_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // Effective values: earliest capped below noon, minimum kept in 0.01..23.99 h
  logic [EarlyW-1:0] early_eff;
  logic [MinW-1:0]   min_eff;

  assign early_eff = (earliest_on_r >= EARLY_LIMIT) ? EARLY_CLAMP : earliest_on_r;
  always_comb begin
    if (min_day_length_r == '0)
      min_eff = MIN_FLOOR;
    else if (min_day_length_r >= MIN_LIMIT)
      min_eff = MIN_CLAMP;
    else
      min_eff = min_day_length_r;
  end

  // ---------------------------------------------------------------
  // Pipeline: whole chain advances unless a result is held
  // ---------------------------------------------------------------
  logic     adv;
  logic     light_on;
  sls_sun_t sun;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  sls_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .in_day   (in_tdata[DayW-1:0]),
    .in_hour  (in_tdata[DayW +: HourW]),
    .sun      (sun)
  );

  sls_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .sun       (sun),
    .early     (early_eff),
    .minlen    (min_eff),
    .out_valid (out_tvalid),
    .light_on  (light_on)
  );

  assign out_tdata = {7'b0, light_on};

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while result held");

  a_early_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[2] == REG_EARLIEST_ON) |=>
      (earliest_on_r == $past(cfg_pwdata[EarlyW-1:0])))
    else $error("earliest_on write lost");

  a_eff_range: assert property (@(posedge clk) disable iff (!rst_n)
    (early_eff < EARLY_LIMIT) && (min_eff >= MIN_FLOOR) && (min_eff <= MIN_CLAMP))
    else $error("effective config out of range");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(sun))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
